### hw/rtl/adjacent_strip_cluster_finder_macros.svh
// ----------------------------------------------------------------------------
// Cluster finder assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ADJACENT_STRIP_CLUSTER_FINDER_MACROS_SVH
`define ADJACENT_STRIP_CLUSTER_FINDER_MACROS_SVH

// condition holds at every edge
`define ASCF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition never holds
`define ASCF_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ascf_pkg.sv
// ----------------------------------------------------------------------------
// Cluster finder package
// Shared constants, queue status and divider state type.
// ----------------------------------------------------------------------------
package ascf_pkg;

	localparam int CHANNEL_BITS_DEF = 10;
	localparam int MAX_HITS_DEF     = 1024;
	localparam int FRAC_BITS_DEF    = 4;

	localparam int CENT_BITS    = 14;
	localparam int CWID_BITS    = 11;
	localparam int M_TDATA_BITS = ((CENT_BITS + CWID_BITS + 7) / 8) * 8;

	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic empty;
		logic room2;
	} q_stat_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

endpackage

### hw/rtl/ascf_front.sv
// ----------------------------------------------------------------------------
// Cluster builder
// Tracks the open cluster and emits closed cluster records, up to two per hit.
// ----------------------------------------------------------------------------
module ascf_front
	import ascf_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	parameter int MAX_HITS     = MAX_HITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] hit_channel,
	input  logic                    event_end,
	input  q_stat_t                 q_stat,
	output logic [1:0]              push_n,
	output logic [CHANNEL_BITS + $clog2(MAX_HITS+1) + $clog2(MAX_HITS+1) + 1:0] rec0,
	output logic [CHANNEL_BITS + $clog2(MAX_HITS+1) + $clog2(MAX_HITS+1) + 1:0] rec1
);

	localparam int WID_BITS = $clog2(MAX_HITS + 1);
	localparam int SUM_BITS = CHANNEL_BITS + WID_BITS;

	logic                    open_q;
	logic [CHANNEL_BITS-1:0] prev_q;
	logic [WID_BITS-1:0]     wid_q;
	logic [SUM_BITS-1:0]     sum_q;

	logic                    accept;
	logic                    adj;
	logic                    close_first;
	logic [WID_BITS-1:0]     wid_new;
	logic [SUM_BITS-1:0]     sum_new;

	assign in_ready = q_stat.room2;
	assign accept   = in_valid && in_ready;

	assign adj = open_q && (({1'b0, hit_channel} == ({1'b0, prev_q} + 1'b1)) ||
		({1'b0, prev_q} == ({1'b0, hit_channel} + 1'b1)));
	assign close_first = open_q && !adj;

	always_comb begin
		wid_new = WID_BITS'(1);
		sum_new = SUM_BITS'(hit_channel);
		if (adj) begin
			wid_new = wid_q;
			sum_new = sum_q;
			if (wid_q < WID_BITS'(MAX_HITS)) begin
				wid_new = wid_q + 1'b1;
				sum_new = sum_q + SUM_BITS'(hit_channel);
			end
		end
	end

	// record: {run_last, event_done, width, sum}
	always_comb begin
		push_n = 2'd0;
		rec0   = {1'b1, 1'b1, wid_new, sum_new};
		rec1   = {1'b1, 1'b1, wid_new, sum_new};
		if (accept) begin
			if (close_first) begin
				rec0   = {!event_end, 1'b0, wid_q, sum_q};
				push_n = event_end ? 2'd2 : 2'd1;
			end else if (event_end) begin
				push_n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			prev_q <= '0;
			wid_q  <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (event_end) begin
				open_q <= 1'b0;
				prev_q <= '0;
				wid_q  <= '0;
				sum_q  <= '0;
			end else begin
				open_q <= 1'b1;
				prev_q <= hit_channel;
				wid_q  <= wid_new;
				sum_q  <= sum_new;
			end
		end
	end

endmodule

### hw/rtl/ascf_queue.sv
// ----------------------------------------------------------------------------
// Cluster record queue
// Small queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module ascf_queue
	import ascf_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   push_n,
	input  logic [W-1:0] wdata0,
	input  logic [W-1:0] wdata1,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output q_stat_t      q_stat
);

	`include "adjacent_strip_cluster_finder_macros.svh"

	localparam int PTR_BITS = $clog2(Q_DEPTH);
	localparam int CNT_BITS = PTR_BITS + 1;

	logic [W-1:0]        mem_q [Q_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [PTR_BITS-1:0] wr_ptr1;

	assign wr_ptr1      = wr_ptr_q + 1'b1;
	assign rdata        = mem_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.room2 = (cnt_q <= CNT_BITS'(Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= wdata0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_BITS'(push_n) - CNT_BITS'(pop);
		end
	end

	`ASCF_ASSERT_ALWAYS(a_q_bound, cnt_q <= CNT_BITS'(Q_DEPTH), "queue count over depth")
	`ASCF_ASSERT_NEVER(a_q_pop_empty, pop && (cnt_q == '0), "pop from empty queue")
	`ASCF_ASSERT_NEXT(a_q_push2, (push_n == 2'd2) && !pop, cnt_q == $past(cnt_q) + CNT_BITS'(2), "queue count lost a double push")

endmodule

### hw/rtl/ascf_back.sv
// ----------------------------------------------------------------------------
// Centroid divider
// Bit-serial restoring divide of sum << FRAC_BITS by width, output register.
// ----------------------------------------------------------------------------
module ascf_back
	import ascf_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	parameter int MAX_HITS     = MAX_HITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  q_stat_t              q_stat,
	input  logic [CHANNEL_BITS + $clog2(MAX_HITS+1) + $clog2(MAX_HITS+1) + 1:0] rdata,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CENT_BITS-1:0] centroid_x16,
	output logic [CWID_BITS-1:0] cluster_width,
	output logic                 event_done,
	output logic                 run_last
);

	localparam int WID_BITS = $clog2(MAX_HITS + 1);
	localparam int SUM_BITS = CHANNEL_BITS + WID_BITS;
	localparam int DIV_BITS = SUM_BITS + FRAC_BITS;
	localparam int CNT_BITS = $clog2(DIV_BITS);

	div_state_t          state_q, state_d;
	logic                load;

	logic [SUM_BITS-1:0] r_sum;
	logic [WID_BITS-1:0] r_wid;
	logic                r_done;
	logic                r_last;

	logic [DIV_BITS-1:0] quo_q;
	logic [WID_BITS-1:0] rem_q;
	logic [WID_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic                last_q;

	logic [WID_BITS:0]   trial;
	logic                ge;
	logic [WID_BITS-1:0] rem_next;

	logic                out_valid_q;

	assign {r_last, r_done, r_wid, r_sum} = rdata;

	assign trial    = {rem_q, quo_q[DIV_BITS-1]};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign rem_next = ge ? WID_BITS'(trial - {1'b0, dvs_q}) : WID_BITS'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			DIV_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DIV_HOLD;
				end
			end
			DIV_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q  <= DIV_BITS'(r_sum) << FRAC_BITS;
			rem_q  <= '0;
			dvs_q  <= r_wid;
			cnt_q  <= CNT_BITS'(DIV_BITS - 1);
			done_q <= r_done;
			last_q <= r_last;
		end else if (state_q == DIV_RUN) begin
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
			rem_q <= rem_next;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			centroid_x16  <= CENT_BITS'(quo_q);
			cluster_width <= CWID_BITS'(dvs_q);
			event_done    <= done_q;
			run_last      <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/adjacent_strip_cluster_finder.sv
// ----------------------------------------------------------------------------
// Adjacent strip cluster finder
// Groups adjacent strip hits into clusters and reports width and centroid.
// ----------------------------------------------------------------------------
// A hit item is taken whenever the record queue has room for two
// clusters. Closed clusters wait in a four-entry queue for a bit-serial
// divider, which works on one cluster at a time, from queue pop through
// its output register; that divider sets the sustained rate. Hits that
// extend clusters cost nothing at the back, so the input keeps up at one
// hit per cycle as long as clusters close no more often than one per
// divide time and m_tready does not hold the output. m_tdata bits 13:0
// hold the centroid with FRAC_BITS fraction bits, bits 24:14 the width.
// ----------------------------------------------------------------------------
module adjacent_strip_cluster_finder
	import ascf_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	parameter int MAX_HITS     = MAX_HITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((CHANNEL_BITS + 7) / 8) * 8-1:0] s_tdata,  // hit_channel
	input  logic                                    s_tlast,  // event_end
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [M_TDATA_BITS-1:0]                 m_tdata,  // centroid_x16, cluster_width
	output logic                                    m_tuser,  // event_done
	output logic                                    m_tlast   // run_last
);

	localparam int WID_BITS = $clog2(MAX_HITS + 1);
	localparam int REC_BITS = CHANNEL_BITS + 2 * WID_BITS + 2;

	q_stat_t              q_stat;
	logic [1:0]           push_n;
	logic [REC_BITS-1:0]  rec0;
	logic [REC_BITS-1:0]  rec1;
	logic [REC_BITS-1:0]  rdata;
	logic                 pop;
	logic [CENT_BITS-1:0] centroid_x16;
	logic [CWID_BITS-1:0] cluster_width;

	ascf_front #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.MAX_HITS    (MAX_HITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.hit_channel(s_tdata[CHANNEL_BITS-1:0]),
		.event_end  (s_tlast),
		.q_stat     (q_stat),
		.push_n     (push_n),
		.rec0       (rec0),
		.rec1       (rec1)
	);

	ascf_queue #(
		.W(REC_BITS)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.wdata0(rec0),
		.wdata1(rec1),
		.pop   (pop),
		.rdata (rdata),
		.q_stat(q_stat)
	);

	ascf_back #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.MAX_HITS    (MAX_HITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.rdata        (rdata),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.centroid_x16 (centroid_x16),
		.cluster_width(cluster_width),
		.event_done   (m_tuser),
		.run_last     (m_tlast)
	);

	assign m_tdata = M_TDATA_BITS'({cluster_width, centroid_x16});

endmodule
